// ===== hw/rtl/integer_matrix_multiply_defines.svh =====
// Assertion macros shared by the integer matrix multiply RTL.
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMM_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("integer_matrix_multiply assertion failed");

// Next-cycle implication, disabled during reset.
`define IMM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("integer_matrix_multiply assertion failed");

`endif

// ===== hw/rtl/imm_pkg.sv =====
// Types and constants shared by the integer matrix multiply modules.
package imm_pkg;

  localparam int ELEM_W = 16;
  localparam int ACC_W  = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;

  localparam logic [1:0] REQ_WRITE_A = 2'd0;
  localparam logic [1:0] REQ_WRITE_B = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  localparam logic REG_DIM_IN_USE = 1'b0;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic clear;
    logic issue;
  } imm_mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } imm_mac_sts_t;

endpackage

// ===== hw/rtl/imm_mem.sv =====
// Single-port-write, single-port-read element memory with registered read data.
module imm_mem
  import imm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [ELEM_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [ELEM_W-1:0] rdata
);

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/imm_mac.sv =====
// Multiply-accumulate datapath fed by the two element memories.
module imm_mac
  import imm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  imm_mac_ctrl_t     ctrl,
  input  logic [ELEM_W-1:0] a_data,
  input  logic [ELEM_W-1:0] b_data,
  output imm_mac_sts_t      sts,
  output logic [ACC_W-1:0]  acc
);

  logic                    rd_vld;
  logic                    prod_vld;
  logic signed [ACC_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= ctrl.issue;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= ACC_W'($signed(a_data) * $signed(b_data));
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign sts.busy = rd_vld | prod_vld;

endmodule

// ===== hw/rtl/integer_matrix_multiply.sv =====
// A read sums n inner terms, n being dim_in_use limited to MATRIX_DIM (zero for an index
// out of range); each term passes the memory read and product registers, and the sum is
// registered to the output. Writes are accepted every cycle while no read is in progress.
// One multiply-accumulate unit steps through both memories, one inner term a cycle.
// Reset is synchronous and active high: it clears control state and sets dim_in_use
// to 8. Matrix contents are not cleared and hold no value until written.
`include "integer_matrix_multiply_defines.svh"

module integer_matrix_multiply
  import imm_pkg::*;
#(
  parameter int MATRIX_DIM = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               req_type,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [ELEM_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ACC_W-1:0]  product
);

  localparam int DEPTH = MATRIX_DIM * MATRIX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int K_W   = $clog2(MATRIX_DIM + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state;
  logic [DIM_W-1:0] dim_in_use;
  logic [K_W-1:0]   k;
  logic [K_W-1:0]   n_run;
  logic [K_W-1:0]   n_sat;
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;

  logic              accept;
  logic              in_range;
  logic              wr_a;
  logic              wr_b;
  logic              start;
  logic              issue;
  logic              load;
  logic              cfg_wr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic [ELEM_W-1:0] a_data;
  logic [ELEM_W-1:0] b_data;
  logic [ACC_W-1:0]  acc;
  imm_mac_ctrl_t     mac_ctrl;
  imm_mac_sts_t      mac_sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_in_use <= DIM_RESET;
    end else if (cfg_wr && paddr[2] == REG_DIM_IN_USE) begin
      dim_in_use <= pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_DIM_IN_USE) begin
      prdata = {{(32 - DIM_W){1'b0}}, dim_in_use};
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    if (32'(dim_in_use) > MATRIX_DIM) begin
      n_sat = K_W'(MATRIX_DIM);
    end else begin
      n_sat = K_W'(dim_in_use);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign in_range = (32'(row) < MATRIX_DIM) && (32'(col) < MATRIX_DIM);
  assign wr_a     = accept && (req_type == REQ_WRITE_A) && in_range;
  assign wr_b     = accept && (req_type == REQ_WRITE_B) && in_range;
  assign start    = accept && (req_type == REQ_READ);
  assign issue    = (state == S_BUSY) && (k < n_run);
  assign load     = (state == S_OUT) && (!out_valid || out_ready);

  assign waddr   = AW'(32'(row) * MATRIX_DIM + 32'(col));
  assign raddr_a = AW'(32'(row_q) * MATRIX_DIM + 32'(k));
  assign raddr_b = AW'(32'(k) * MATRIX_DIM + 32'(col_q));

  assign mac_ctrl.clear = start;
  assign mac_ctrl.issue = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_BUSY;
            k     <= '0;
          end
        end
        S_BUSY: begin
          if (issue) begin
            k <= k + K_W'(1);
          end else if (!mac_sts.busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row_q <= row;
      col_q <= col;
      n_run <= in_range ? n_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row <= row_q;
      out_col <= col_q;
      product <= acc;
    end
  end

  imm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (a_data)
  );

  imm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (b_data)
  );

  imm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a_data (a_data),
    .b_data (b_data),
    .sts    (mac_sts),
    .acc    (acc)
  );

  `IMM_ASSERT_IMPLY(a_idle_mac_quiet, clk, rst, in_ready, !mac_sts.busy)
  `IMM_ASSERT_IMPLY(a_no_write_busy, clk, rst, state != S_IDLE, !wr_a && !wr_b)
  `IMM_ASSERT_NEXT(a_start_busy, clk, rst, start, state == S_BUSY && k == '0)
  `IMM_ASSERT_IMPLY(a_count_bound, clk, rst, state == S_BUSY, k <= n_run)
  `IMM_ASSERT_NEXT(a_load_valid, clk, rst, load, out_valid && state == S_IDLE)

endmodule

// ===== tb/integer_matrix_multiply_test.sv =====
// Self-checking testbench for integer_matrix_multiply: random and directed element writes and product reads.
module integer_matrix_multiply_test;
  import imm_pkg::*;

  localparam int MATRIX_DIM = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int WORDS_PER_PHASE = 70;
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam logic [2:0] DIM_ADDR = {REG_DIM_IN_USE, 2'b00};

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         row_idx;
    logic [IDX_W-1:0]         col_idx;
    logic signed [ELEM_W-1:0] elem;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row_idx;
    logic [IDX_W-1:0]        col_idx;
    logic signed [ACC_W-1:0] sum;
  } product_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [IDX_W-1:0] row = '0;
  logic [IDX_W-1:0] col = '0;
  logic signed [ELEM_W-1:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic signed [ACC_W-1:0] product;

  request_t queued_requests[$];
  product_t expected_products[$];
  request_t driven_req;
  logic signed [ELEM_W-1:0] elem_a [MATRIX_DIM][MATRIX_DIM];
  logic signed [ELEM_W-1:0] elem_b [MATRIX_DIM][MATRIX_DIM];
  bit written_a [MATRIX_DIM][MATRIX_DIM];
  bit written_b [MATRIX_DIM][MATRIX_DIM];
  logic [DIM_W-1:0] cfg_dim = DIM_RESET;
  int idle_pct = 9;
  int errors = 0;
  int cycle_count = 0;

  integer_matrix_multiply #(.MATRIX_DIM(MATRIX_DIM)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .row(row), .col(col), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .product(product)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < MATRIX_DIM; i++) begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
        elem_a[i][j] = '0;
        elem_b[i][j] = '0;
      end
    end
  end

  function automatic void apply_request(input request_t req);
    logic signed [ACC_W-1:0] sum;
    product_t res;
    int terms;
    sum = '0;
    terms = (cfg_dim > MATRIX_DIM) ? MATRIX_DIM : int'(cfg_dim);
    case (req.kind)
      REQ_WRITE_A: elem_a[req.row_idx][req.col_idx] = req.elem;
      REQ_WRITE_B: elem_b[req.row_idx][req.col_idx] = req.elem;
      REQ_READ: begin
        for (int k = 0; k < terms; k++) begin
          sum += elem_a[req.row_idx][k] * elem_b[k][req.col_idx];
        end
        res.row_idx = req.row_idx;
        res.col_idx = req.col_idx;
        res.sum = sum;
        expected_products.push_back(res);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(driven_req);
      end
      if (!in_valid || in_ready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          driven_req = queued_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= driven_req.kind;
          row <= driven_req.row_idx;
          col <= driven_req.col_idx;
          value <= driven_req.elem;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    product_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
      if (out_valid && out_ready) begin
        if (expected_products.size() == 0) begin
          $error("product word with none expected: row %0d col %0d value %0d",
                 out_row, out_col, product);
          errors++;
        end else begin
          want = expected_products.pop_front();
          if (out_row !== want.row_idx) begin
            $error("out_row expected %0d actual %0d", want.row_idx, out_row);
            errors++;
          end
          if (out_col !== want.col_idx) begin
            $error("out_col expected %0d actual %0d", want.col_idx, out_col);
            errors++;
          end
          if (product !== want.sum) begin
            $error("product expected %0d actual %0d", want.sum, product);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [ELEM_W-1:0] random_elem();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'shffff;
      3: return 16'sh0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v);
    request_t req;
    req.kind = kind;
    req.row_idx = r;
    req.col_idx = c;
    req.elem = v;
    if (kind == REQ_WRITE_A) written_a[r][c] = 1'b1;
    if (kind == REQ_WRITE_B) written_b[r][c] = 1'b1;
    queued_requests.push_back(req);
  endtask

  // Finds an element that a read of (r, c) would use but that has not been written yet.
  function automatic bit find_gap(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                  input int terms, output logic [1:0] kind,
                                  output logic [IDX_W-1:0] gr, output logic [IDX_W-1:0] gc);
    for (int k = 0; k < terms; k++) begin
      if (!written_a[r][k]) begin
        kind = REQ_WRITE_A;
        gr = r;
        gc = IDX_W'(k);
        return 1'b1;
      end
      if (!written_b[k][c]) begin
        kind = REQ_WRITE_B;
        gr = IDX_W'(k);
        gc = c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic program_dim(input logic [DIM_W-1:0] dim);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DIM_ADDR;
    pwdata <= 32'(dim);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_dim = dim;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (queued_requests.size() != 0 || in_valid || expected_products.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [DIM_W-1:0] phase_dims [9];
    logic [1:0] gap_kind;
    logic [IDX_W-1:0] gap_row;
    logic [IDX_W-1:0] gap_col;
    logic [IDX_W-1:0] rr;
    logic [IDX_W-1:0] cc;
    int terms;
    int made;
    int pick;
    phase_dims = '{4'd8, 4'd15, 4'd3, 4'd1, 4'd0, 4'd5, 4'd8, 4'd12, 4'd2};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A single inner term exposes the signed extremes directly.
    program_dim(4'd1);
    queue_item(REQ_WRITE_A, 3'd0, 3'd0, 16'sh8000);
    queue_item(REQ_WRITE_B, 3'd0, 3'd0, 16'sh8000);
    queue_item(REQ_READ, 3'd0, 3'd0, 16'sh0000);
    queue_item(REQ_WRITE_A, 3'd0, 3'd0, 16'sh7fff);
    queue_item(REQ_READ, 3'd0, 3'd0, 16'shffff);
    queue_item(REQ_WRITE_B, 3'd0, 3'd0, 16'sh7fff);
    queue_item(REQ_READ, 3'd0, 3'd0, 16'sh5a5a);
    queue_item(REQ_WRITE_A, 3'd7, 3'd0, 16'shffff);
    queue_item(REQ_WRITE_B, 3'd0, 3'd7, 16'sh0001);
    queue_item(REQ_READ, 3'd7, 3'd7, 16'sha5a5);
    queue_item(REQ_IGNORED, 3'd5, 3'd2, 16'shffff);
    queue_item(REQ_READ, 3'd7, 3'd0, 16'sh0000);
    drain();

    // Two maximal terms overflow to the most negative sum.
    program_dim(4'd2);
    queue_item(REQ_WRITE_A, 3'd0, 3'd0, 16'sh8000);
    queue_item(REQ_WRITE_B, 3'd0, 3'd0, 16'sh8000);
    queue_item(REQ_WRITE_A, 3'd0, 3'd1, 16'sh8000);
    queue_item(REQ_WRITE_B, 3'd1, 3'd0, 16'sh8000);
    queue_item(REQ_READ, 3'd0, 3'd0, 16'sh0000);
    drain();

    // With no terms in use every read is zero.
    program_dim(4'd0);
    queue_item(REQ_READ, 3'd3, 3'd5, 16'sh1234);
    queue_item(REQ_READ, 3'd7, 3'd7, 16'shffff);
    queue_item(REQ_WRITE_A, 3'd7, 3'd7, 16'sh3039);

    for (int p = 0; p < 9; p++) begin
      drain();
      idle_pct = (p == 2) ? 0 : 9;
      program_dim(phase_dims[p]);
      terms = (phase_dims[p] > MATRIX_DIM) ? MATRIX_DIM : int'(phase_dims[p]);
      made = 0;
      while (made < WORDS_PER_PHASE) begin
        pick = $urandom_range(99);
        rr = IDX_W'($urandom_range(7));
        cc = IDX_W'($urandom_range(7));
        if (pick < 5) begin
          queue_item(REQ_IGNORED, rr, cc, random_elem());
        end else if (pick < 40) begin
          queue_item(pick[0] ? REQ_WRITE_A : REQ_WRITE_B, rr, cc, random_elem());
          made++;
        end else if (find_gap(rr, cc, terms, gap_kind, gap_row, gap_col)) begin
          queue_item(gap_kind, gap_row, gap_col, random_elem());
          made++;
        end else begin
          queue_item(REQ_READ, rr, cc, random_elem());
          made++;
        end
      end
    end
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== integer_matrix_multiply.f =====
+incdir+hw/rtl
hw/rtl/imm_pkg.sv
hw/rtl/imm_mem.sv
hw/rtl/imm_mac.sv
hw/rtl/integer_matrix_multiply.sv
tb/integer_matrix_multiply_test.sv
